### src/anbs_pkg.sv
package anbs_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       key_hint;
   } req_type;

   typedef struct packed {
      logic [5:0]  nal_type;
      logic [23:0] nal_length;
      logic        frame_end;
      logic        key_flag;
      logic        has_vps;
      logic        has_sps;
      logic        has_pps;
      logic        params_complete;
      logic        no_nal_error;
      logic        last_of_run;
   } rsp_type;

   // one scan decision handed from the front to the back
   typedef struct packed {
      logic       take;
      logic       start;
      logic       frame_last;
      logic       flush;
      logic       hint;
      logic [7:0] data_byte;
   } op_type;

   typedef struct packed {
      logic key;
      logic vps;
      logic sps;
      logic pps;
      logic any;
   } flags_type;

   localparam int OP_DEPTH  = 4;
   localparam int RSP_DEPTH = 4;

   localparam logic CSR_CODEC_SELECT = 1'b0;
   localparam logic CODEC_H264       = 1'b0;
   localparam logic CODEC_H265       = 1'b1;

   localparam logic [5:0] H264_IDR      = 6'd5;
   localparam logic [5:0] H264_SPS      = 6'd7;
   localparam logic [5:0] H264_PPS      = 6'd8;
   localparam logic [5:0] H265_IRAP_LO  = 6'd16;
   localparam logic [5:0] H265_IRAP_HI  = 6'd21;
   localparam logic [5:0] H265_VPS      = 6'd32;
   localparam logic [5:0] H265_SPS      = 6'd33;
   localparam logic [5:0] H265_PPS      = 6'd34;

endpackage

### src/annexb_nal_unit_scanner_top.sv
// Annex B NAL unit scanner.
// Request side is a queue write port: a byte beat (data byte, last-byte mark,
// key hint) is taken on a clock edge with req_push high and req_full low.
// Result side is a queue read port: the oldest result sits on rsp_data while
// rsp_empty is low and is taken with rsp_pop. One result per non-empty unit;
// the frame summary rides on the frame's final result, sent even if empty.
// Throughput: one byte per cycle while req_full is low. After a last-byte beat
// req_full stays high while the front drains its four-byte window, one scan
// decision per cycle while the decision queue has room.
// A unit result passes through the decision queue, then the result queue,
// after the beat that puts the next start code at the head of a full
// four-byte window (the byte after a three-byte code, the final byte of a
// four-byte code); the frame result follows once the window has drained.
// When the result reader stalls, a four-entry result queue and a four-entry
// decision queue absorb the backlog before req_full rises.
// Reset (synchronous) empties both queues, clears the window and unit state
// and sets codec_select to H.264. Write codec_select only while idle.
module annexb_nal_unit_scanner_top #(
   parameter int LENGTH_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  anbs_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output anbs_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int OP_BITS  = $bits(anbs_pkg::op_type);
   localparam int RSP_BITS = $bits(anbs_pkg::rsp_type);

   logic                codec_ff;
   logic                op_push, op_full, op_empty, op_pop;
   anbs_pkg::op_type    op_in, op_out;
   logic [OP_BITS-1:0]  op_bits;
   logic                rsp_push, rsp_full;
   anbs_pkg::rsp_type   rsp_in;
   logic [RSP_BITS-1:0] rsp_bits;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == anbs_pkg::CSR_CODEC_SELECT) ? {31'd0, codec_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff <= anbs_pkg::CODEC_H264;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == anbs_pkg::CSR_CODEC_SELECT)) begin
         codec_ff <= csr_pwdata[0];
      end
   end

   anbs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .op_push  (op_push),
      .op_data  (op_in),
      .op_full  (op_full)
   );

   anbs_fifo #(
      .WIDTH (OP_BITS),
      .DEPTH (anbs_pkg::OP_DEPTH)
   ) u_op_q (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (op_bits),
      .empty     (op_empty)
   );

   assign op_out = anbs_pkg::op_type'(op_bits);

   anbs_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .codec_select (codec_ff),
      .op_valid     (!op_empty),
      .op_data      (op_out),
      .op_pop       (op_pop),
      .rsp_push     (rsp_push),
      .rsp_data     (rsp_in),
      .rsp_full     (rsp_full)
   );

   anbs_fifo #(
      .WIDTH (RSP_BITS),
      .DEPTH (anbs_pkg::RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp_data = anbs_pkg::rsp_type'(rsp_bits);

endmodule

### src/anbs_fifo.sv
module anbs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         if (do_push && !do_pop) count_ff <= count_ff + CNT_BITS'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### src/anbs_front.sv
module anbs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  anbs_pkg::req_type req_data,
   output logic              req_full,
   output logic              op_push,
   output anbs_pkg::op_type  op_data,
   input  logic              op_full
);

   logic [31:0] win_ff, win_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        flush_ff, flush_in;
   logic        hint_ff, hint_in;
   logic        accept;
   logic [31:0] b;
   logic [2:0]  n;
   logic [2:0]  used;

   // bytes consumed by one decision at the window head: 3 or 4 on a start code, else 1
   function automatic logic [2:0] decide_used(input logic [31:0] w, input logic [2:0] m);
      logic code3, code4;
      code3 = (m >= 3'd3) && (w[7:0] == 8'h00) && (w[15:8] == 8'h00) && (w[23:16] == 8'h01);
      code4 = (m == 3'd4) && (w[7:0] == 8'h00) && (w[15:8] == 8'h00) &&
              (w[23:16] == 8'h00) && (w[31:24] == 8'h01);
      if (code3) return 3'd3;
      else if (code4) return 3'd4;
      else return 3'd1;
   endfunction

   always_comb begin
      win_in   = win_ff;
      cnt_in   = cnt_ff;
      flush_in = flush_ff;
      hint_in  = hint_ff;
      req_full = flush_ff || op_full;
      accept   = req_push && !req_full;
      op_push  = 1'b0;
      op_data  = '0;
      used     = 3'd1;
      b        = win_ff;
      b[{cnt_ff[1:0], 3'b000} +: 8] = req_data.data_byte;
      n        = cnt_ff + 3'd1;

      if (flush_ff) begin
         used = decide_used(win_ff, cnt_ff);
         if (!op_full) begin
            op_push            = 1'b1;
            op_data.take       = (used == 3'd1);
            op_data.start      = (used != 3'd1);
            op_data.frame_last = (used == cnt_ff);
            op_data.flush      = 1'b1;
            op_data.hint       = hint_ff;
            op_data.data_byte  = win_ff[7:0];
            win_in             = win_ff >> {used, 3'b000};
            cnt_in             = cnt_ff - used;
            if (used == cnt_ff) flush_in = 1'b0;
         end
      end else if (accept) begin
         if (req_data.last_byte) begin
            win_in   = b;
            cnt_in   = n;
            flush_in = 1'b1;
            hint_in  = req_data.key_hint;
         end else if (n == 3'd4) begin
            used              = decide_used(b, n);
            op_push           = 1'b1;
            op_data.take      = (used == 3'd1);
            op_data.start     = (used != 3'd1);
            op_data.data_byte = b[7:0];
            win_in            = b >> {used, 3'b000};
            cnt_in            = n - used;
         end else begin
            win_in = b;
            cnt_in = n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         flush_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         flush_ff <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      hint_ff <= hint_in;
   end

endmodule

### src/anbs_back.sv
module anbs_back #(
   parameter int LENGTH_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              codec_select,
   input  logic              op_valid,
   input  anbs_pkg::op_type  op_data,
   output logic              op_pop,
   output logic              rsp_push,
   output anbs_pkg::rsp_type rsp_data,
   input  logic              rsp_full
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   logic                    inside_ff, inside_in;
   logic [LENGTH_BITS-1:0]  len_ff, len_in;
   logic [7:0]              first_ff, first_in;
   anbs_pkg::flags_type     flags_ff, flags_in;
   logic                    phase_ff, phase_in;

   logic                    start_now, end_now, nonempty, need_out, go;
   logic [LENGTH_BITS-1:0]  t_len;
   logic [7:0]              t_first;
   logic [5:0]              nal_type;
   logic [31:0]             len_ext;
   anbs_pkg::flags_type     unit_flags, flags_new;
   logic                    vps, vps_ok;

   always_comb begin
      start_now = op_data.start && !phase_ff;
      end_now   = op_data.frame_last && !start_now;

      t_len   = len_ff;
      t_first = first_ff;
      if (op_data.take && inside_ff) begin
         if (len_ff == '0) t_first = op_data.data_byte;
         if (len_ff != LEN_MAX) t_len = len_ff + LENGTH_BITS'(1);
      end
      nonempty = inside_ff && (t_len != '0);
      len_ext  = 32'(t_len);

      unit_flags = '0;
      if (codec_select == anbs_pkg::CODEC_H265) begin
         nal_type = (t_len > LENGTH_BITS'(1)) ? t_first[6:1] : 6'd0;
         unit_flags.key = (nal_type >= anbs_pkg::H265_IRAP_LO) &&
                          (nal_type <= anbs_pkg::H265_IRAP_HI);
         unit_flags.vps = (nal_type == anbs_pkg::H265_VPS);
         unit_flags.sps = (nal_type == anbs_pkg::H265_SPS);
         unit_flags.pps = (nal_type == anbs_pkg::H265_PPS);
      end else begin
         nal_type = {1'b0, t_first[4:0]};
         unit_flags.key = (nal_type == anbs_pkg::H264_IDR);
         unit_flags.sps = (nal_type == anbs_pkg::H264_SPS);
         unit_flags.pps = (nal_type == anbs_pkg::H264_PPS);
      end
      unit_flags.any = 1'b1;
      flags_new = nonempty ? (flags_ff | unit_flags) : flags_ff;

      vps    = (codec_select == anbs_pkg::CODEC_H265) && flags_new.vps;
      vps_ok = (codec_select == anbs_pkg::CODEC_H265) ? vps : 1'b1;

      need_out = (start_now && nonempty) || end_now;
      go       = op_valid && (!need_out || !rsp_full);
      rsp_push = go && need_out;
      op_pop   = go && !(start_now && op_data.frame_last);

      rsp_data            = '0;
      rsp_data.nal_type   = nonempty ? nal_type : 6'd0;
      rsp_data.nal_length = nonempty ? len_ext[23:0] : 24'd0;
      rsp_data.last_of_run = end_now || !op_data.flush;
      if (end_now) begin
         rsp_data.frame_end       = 1'b1;
         rsp_data.key_flag        = flags_new.key || op_data.hint;
         rsp_data.has_vps         = vps;
         rsp_data.has_sps         = flags_new.sps;
         rsp_data.has_pps         = flags_new.pps;
         rsp_data.params_complete = vps_ok && flags_new.sps && flags_new.pps;
         rsp_data.no_nal_error    = !flags_new.any;
      end

      inside_in = inside_ff;
      len_in    = len_ff;
      first_in  = first_ff;
      flags_in  = flags_ff;
      phase_in  = phase_ff;
      if (go) begin
         if (end_now) begin
            inside_in = 1'b0;
            len_in    = '0;
            flags_in  = '0;
            phase_in  = 1'b0;
         end else if (start_now) begin
            inside_in = 1'b1;
            len_in    = '0;
            flags_in  = flags_new;
            phase_in  = op_data.frame_last;
         end else begin
            len_in   = t_len;
            first_in = t_first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         len_ff    <= '0;
         flags_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         inside_ff <= inside_in;
         len_ff    <= len_in;
         flags_ff  <= flags_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
   end

endmodule
